FILE: rtl/rgb2uyvy_pkg.sv
package rgb2uyvy_pkg;

    // Luma weights, 16-bit fixed point
    localparam int unsigned CoefR = 19595;
    localparam int unsigned CoefG = 38470;
    localparam int unsigned CoefB = 7471;

    localparam int PROD_W = 24;
    localparam int K_W    = 6;

    typedef logic [63:0][7:0]  t_tab64;
    typedef logic [255:0][7:0] t_tab256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb px0;
        t_rgb px1;
        logic last;
    } t_pair_in;

    typedef struct packed {
        logic [PROD_W-1:0] pr;
        logic [PROD_W-1:0] pg;
        logic [PROD_W-1:0] pb;
        logic [7:0]        red;
        logic [7:0]        blue;
    } t_pix_prod;

    typedef struct packed {
        t_pix_prod p0;
        t_pix_prod p1;
        logic      last;
    } t_prod;

    typedef struct packed {
        logic [7:0] y0;
        logic [7:0] y1;
        logic [7:0] red0;
        logic [7:0] blue0;
        logic [7:0] red1;
        logic [7:0] blue1;
        logic       last;
    } t_luma;

    typedef struct packed {
        logic [7:0]     yo0;
        logic [7:0]     yo1;
        logic [K_W-1:0] ku0;
        logic [K_W-1:0] kv0;
        logic [K_W-1:0] ku1;
        logic [K_W-1:0] kv1;
        logic           last;
    } t_idx;

    typedef struct packed {
        logic [7:0] yo0;
        logic [7:0] yo1;
        logic [7:0] u0;
        logic [7:0] v0;
        logic [7:0] u1;
        logic [7:0] v1;
        logic       last;
    } t_chroma;

    function automatic logic [7:0] clamp_byte(input int v);
        logic [7:0] res;
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 255) begin
            res = 8'd255;
        end else begin
            res = 8'(v);
        end
        return res;
    endfunction

    // Entry i holds the chroma for the 6-bit two's complement index i
    function automatic t_tab64 gen_u_tab();
        t_tab64 tab;
        int     k;
        for (int i = 0; i < 64; i++) begin
            k = (i >= 32) ? i - 64 : i;
            tab[i] = clamp_byte((k * 113) / 25 + 128);
        end
        return tab;
    endfunction

    function automatic t_tab64 gen_v_tab();
        t_tab64 tab;
        int     k;
        for (int i = 0; i < 64; i++) begin
            k = (i >= 32) ? i - 64 : i;
            tab[i] = clamp_byte((k * 713) / 125 + 128);
        end
        return tab;
    endfunction

    function automatic t_tab256 gen_yo_tab();
        t_tab256 tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = 8'(16 + (219 * i) / 255);
        end
        return tab;
    endfunction

    localparam t_tab64  U_TAB  = gen_u_tab();
    localparam t_tab64  V_TAB  = gen_v_tab();
    localparam t_tab256 YO_TAB = gen_yo_tab();

    // (c - y) / 8 with truncation toward zero, as a 6-bit two's complement index
    function automatic logic [K_W-1:0] div8_trunc(input logic [7:0] c, input logic [7:0] y);
        logic signed [8:0] d;
        d = $signed({1'b0, c}) - $signed({1'b0, y});
        if (d < 0) begin
            d = d + 9'sd7;
        end
        return d[8:3];
    endfunction

endpackage

FILE: rtl/rgb2uyvy_luma.sv
module rgb2uyvy_luma (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  rgb2uyvy_pkg::t_pair_in  i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output rgb2uyvy_pkg::t_luma     o_data
);
    import rgb2uyvy_pkg::*;

    logic    r_p_valid;
    t_prod   r_prod;
    t_prod   n_prod;
    logic    r_y_valid;
    t_luma   r_luma;
    t_luma   n_luma;
    logic    stall_y;
    logic    stall_p;
    logic [PROD_W-1:0] sum0;
    logic [PROD_W-1:0] sum1;

    function automatic t_pix_prod pix_prod(input t_rgb px);
        t_pix_prod p;
        p.pr   = PROD_W'(px.red)   * PROD_W'(CoefR);
        p.pg   = PROD_W'(px.green) * PROD_W'(CoefG);
        p.pb   = PROD_W'(px.blue)  * PROD_W'(CoefB);
        p.red  = px.red;
        p.blue = px.blue;
        return p;
    endfunction

    assign stall_y = r_y_valid && i_stall;
    assign stall_p = r_p_valid && stall_y;
    assign o_stall = stall_p;

    always_comb begin
        n_prod.p0   = pix_prod(i_data.px0);
        n_prod.p1   = pix_prod(i_data.px1);
        n_prod.last = i_data.last;
    end

    assign sum0 = r_prod.p0.pr + r_prod.p0.pg + r_prod.p0.pb;
    assign sum1 = r_prod.p1.pr + r_prod.p1.pg + r_prod.p1.pb;

    always_comb begin
        n_luma.y0    = sum0[PROD_W-1:PROD_W-8];
        n_luma.y1    = sum1[PROD_W-1:PROD_W-8];
        n_luma.red0  = r_prod.p0.red;
        n_luma.blue0 = r_prod.p0.blue;
        n_luma.red1  = r_prod.p1.red;
        n_luma.blue1 = r_prod.p1.blue;
        n_luma.last  = r_prod.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_y_valid <= 1'b0;
        end else begin
            if (!stall_p) begin
                r_p_valid <= i_valid;
            end
            if (!stall_y) begin
                r_y_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall_p && i_valid) begin
            r_prod <= n_prod;
        end
        if (!stall_y && r_p_valid) begin
            r_luma <= n_luma;
        end
    end

    assign o_valid = r_y_valid;
    assign o_data  = r_luma;

endmodule

FILE: rtl/rgb2uyvy_chroma.sv
module rgb2uyvy_chroma (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  rgb2uyvy_pkg::t_luma     i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output rgb2uyvy_pkg::t_chroma   o_data
);
    import rgb2uyvy_pkg::*;

    logic    r_k_valid;
    t_idx    r_idx;
    t_idx    n_idx;
    logic    r_c_valid;
    t_chroma r_chroma;
    t_chroma n_chroma;
    logic    stall_c;
    logic    stall_k;

    assign stall_c = r_c_valid && i_stall;
    assign stall_k = r_k_valid && stall_c;
    assign o_stall = stall_k;

    // Chroma index and luma rescale
    always_comb begin
        n_idx.yo0  = YO_TAB[i_data.y0];
        n_idx.yo1  = YO_TAB[i_data.y1];
        n_idx.ku0  = div8_trunc(i_data.blue0, i_data.y0);
        n_idx.kv0  = div8_trunc(i_data.red0,  i_data.y0);
        n_idx.ku1  = div8_trunc(i_data.blue1, i_data.y1);
        n_idx.kv1  = div8_trunc(i_data.red1,  i_data.y1);
        n_idx.last = i_data.last;
    end

    // Chroma table lookup
    always_comb begin
        n_chroma.yo0  = r_idx.yo0;
        n_chroma.yo1  = r_idx.yo1;
        n_chroma.u0   = U_TAB[r_idx.ku0];
        n_chroma.v0   = V_TAB[r_idx.kv0];
        n_chroma.u1   = U_TAB[r_idx.ku1];
        n_chroma.v1   = V_TAB[r_idx.kv1];
        n_chroma.last = r_idx.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (!stall_k) begin
                r_k_valid <= i_valid;
            end
            if (!stall_c) begin
                r_c_valid <= r_k_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall_k && i_valid) begin
            r_idx <= n_idx;
        end
        if (!stall_c && r_k_valid) begin
            r_chroma <= n_chroma;
        end
    end

    assign o_valid = r_c_valid;
    assign o_data  = r_chroma;

endmodule

FILE: rtl/rgb2uyvy_out.sv
module rgb2uyvy_out (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_doubled,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  rgb2uyvy_pkg::t_chroma   i_data,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [31:0]             o_word,
    output logic                    o_last_of_run,
    output logic                    o_line_end
);
    import rgb2uyvy_pkg::*;

    logic    r_valid;
    logic    r_second;
    t_chroma r_data;
    logic    fin;

    // Final word of the held item
    assign fin     = !i_doubled || r_second;
    assign o_stall = r_valid && !(fin && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (!o_stall) begin
            r_valid  <= i_valid;
            r_second <= 1'b0;
        end else if (r_valid && !i_stall) begin
            r_second <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

    always_comb begin
        if (!i_doubled) begin
            o_word = {r_data.yo1, r_data.v0, r_data.yo0, r_data.u0};
        end else if (!r_second) begin
            o_word = {r_data.yo0, r_data.v0, r_data.yo0, r_data.u0};
        end else begin
            o_word = {r_data.yo1, r_data.v1, r_data.yo1, r_data.u1};
        end
    end

    assign o_valid       = r_valid;
    assign o_last_of_run = fin;
    assign o_line_end    = fin && r_data.last;

endmodule

FILE: rtl/rgb_pair_to_uyvy_packer_unit.sv
// Each pair passes the product, luma, index, chroma and output registers in turn.
// Throughput: one pair per cycle in pair mode when not stalled; in doubled mode the
// output register emits two words per pair, taking a new pair only with the second.
// Reset (i_rst_n low, synchronous) empties every stage and returns doubled mode
// to pair mode; payload registers are not cleared.
module rgb_pair_to_uyvy_packer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: doubled mode
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    // input pairs
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_red_first,
    input  logic [7:0]  i_green_first,
    input  logic [7:0]  i_blue_first,
    input  logic [7:0]  i_red_second,
    input  logic [7:0]  i_green_second,
    input  logic [7:0]  i_blue_second,
    input  logic        i_last_pair,
    // output words
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_packed_word,
    output logic        o_last_of_run,
    output logic        o_line_end
);
    import rgb2uyvy_pkg::*;

    logic     r_doubled;
    t_pair_in in_data;
    t_luma    luma_data;
    logic     luma_valid;
    logic     luma_stall;
    t_chroma  chroma_data;
    logic     chroma_valid;
    logic     chroma_stall;

    // Mode register: the user must write it only while the block is idle, so no item sees it change; not enforced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doubled <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_doubled <= i_cfg_wr_data;
        end
    end

    assign in_data.px0.red   = i_red_first;
    assign in_data.px0.green = i_green_first;
    assign in_data.px0.blue  = i_blue_first;
    assign in_data.px1.red   = i_red_second;
    assign in_data.px1.green = i_green_second;
    assign in_data.px1.blue  = i_blue_second;
    assign in_data.last      = i_last_pair;

    // Stages one and two: weighted products, then luma sum
    rgb2uyvy_luma u_luma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (in_data),
        .o_valid (luma_valid),
        .i_stall (luma_stall),
        .o_data  (luma_data)
    );

    // Stages three and four: chroma index and luma rescale, then chroma lookup
    rgb2uyvy_chroma u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (luma_valid),
        .o_stall (luma_stall),
        .i_data  (luma_data),
        .o_valid (chroma_valid),
        .i_stall (chroma_stall),
        .o_data  (chroma_data)
    );

    // Output register: packs and, in doubled mode, sends the two words in turn
    rgb2uyvy_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_doubled     (r_doubled),
        .i_valid       (chroma_valid),
        .o_stall       (chroma_stall),
        .i_data        (chroma_data),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_word        (o_packed_word),
        .o_last_of_run (o_last_of_run),
        .o_line_end    (o_line_end)
    );

    // The first word of a doubled item is always followed by its second word
    a_second_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run && !i_out_stall |=> o_out_valid && o_last_of_run)
        else $error("second word of a doubled item missing");

    // Line end only ever marks the last word of an item
    a_line_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> o_last_of_run)
        else $error("line end on a non-final word");

    // Input backpressure only arises with a word held at the output
    a_stall_needs_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output register");

endmodule

FILE: sim/uyvy_word_checker.sv
module uyvy_word_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  rgb2uyvy_pkg::t_pair_in i_pair,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [31:0]            i_packed_word,
    input  logic                   i_last_of_run,
    input  logic                   i_line_end,
    output int                     o_fail_count,
    output int                     o_words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2uyvy_pkg::*;

    localparam int unsigned LUMA_WR = 19595;
    localparam int unsigned LUMA_WG = 38470;
    localparam int unsigned LUMA_WB = 7471;
    localparam int          U_NUM   = 113;
    localparam int          U_DEN   = 25;
    localparam int          V_NUM   = 713;
    localparam int          V_DEN   = 125;

    typedef struct packed {
        logic [31:0] word;
        logic        last_of_run;
        logic        line_end;
    } t_uyvy_word;

    t_uyvy_word expected_words[$];
    logic       doubled_mode;
    int         fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [7:0] luma8(t_rgb px);
        int unsigned acc;
        acc = px.red * LUMA_WR + px.green * LUMA_WG + px.blue * LUMA_WB;
        return acc[23:16];
    endfunction

    // chroma from a colour/luma difference, index truncated toward zero
    function automatic logic [7:0] chroma8(logic [7:0] c, logic [7:0] y, int num, int den);
        int k;
        int v;
        k = (int'(c) - int'(y)) / 8;
        v = (k * num) / den + 128;
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return v[7:0];
    endfunction

    function automatic logic [7:0] studio_luma(logic [7:0] y);
        return 8'(16 + (219 * int'(y)) / 255);
    endfunction

    task automatic push_expected_words(t_pair_in p);
        logic [7:0] y0, y1, yo0, yo1, u0, v0, u1, v1;
        t_uyvy_word w;
        y0  = luma8(p.px0);
        y1  = luma8(p.px1);
        yo0 = studio_luma(y0);
        yo1 = studio_luma(y1);
        u0  = chroma8(p.px0.blue, y0, U_NUM, U_DEN);
        v0  = chroma8(p.px0.red, y0, V_NUM, V_DEN);
        if (doubled_mode) begin
            u1 = chroma8(p.px1.blue, y1, U_NUM, U_DEN);
            v1 = chroma8(p.px1.red, y1, V_NUM, V_DEN);
            w  = '{word: {yo0, v0, yo0, u0}, last_of_run: 1'b0, line_end: 1'b0};
            expected_words.push_back(w);
            w  = '{word: {yo1, v1, yo1, u1}, last_of_run: 1'b1, line_end: p.last};
            expected_words.push_back(w);
        end else begin
            w = '{word: {yo1, v0, yo0, u0}, last_of_run: 1'b1, line_end: p.last};
            expected_words.push_back(w);
        end
    endtask

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %08h, actual %08h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_word();
        t_uyvy_word want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %08h", $time,
                     i_packed_word);
            fail_count++;
        end else begin
            want = expected_words.pop_front();
            report_field("packed_word", want.word, i_packed_word);
            report_field("last_of_run", 32'(want.last_of_run), 32'(i_last_of_run));
            report_field("line_end", 32'(want.line_end), 32'(i_line_end));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            doubled_mode = 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                doubled_mode = i_cfg_wr_data;
            end
            if (i_out_valid && !i_out_stall) begin
                check_word();
            end
            if (i_in_valid && !i_in_stall) begin
                push_expected_words(i_pair);
            end
        end
        o_words_pending <= expected_words.size();
    end

endmodule

FILE: sim/tb_rgb_pair_to_uyvy_packer_unit.sv
module tb_rgb_pair_to_uyvy_packer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rgb2uyvy_pkg::*;

    // values written to the doubled-mode register
    localparam logic MODE_PAIR    = 1'b0;
    localparam logic MODE_DOUBLED = 1'b1;

    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 285;
    // the pipeline is five deep; give it comfortably more before touching the mode
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_RARE,
        STALL_EVERY_THIRD,
        STALL_RUNS
    } t_stall_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_pair_in    pair_d;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_packed_word;
    logic        o_last_of_run;
    logic        o_line_end;

    int   fail_count;
    int   words_pending;
    int   burst_left    = 0;
    int   line_left     = 0;
    int   idle_cycles   = 0;
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;

    always #1 i_clk = ~i_clk;

    rgb_pair_to_uyvy_packer_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_red_first    (pair_d.px0.red),
        .i_green_first  (pair_d.px0.green),
        .i_blue_first   (pair_d.px0.blue),
        .i_red_second   (pair_d.px1.red),
        .i_green_second (pair_d.px1.green),
        .i_blue_second  (pair_d.px1.blue),
        .i_last_pair    (pair_d.last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_packed_word  (o_packed_word),
        .o_last_of_run  (o_last_of_run),
        .o_line_end     (o_line_end)
    );

    // The checker sits beside the block, watches both channels and the
    // register port, and keeps its own queue of the words still owed.
    uyvy_word_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_pair          (pair_d),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_packed_word   (o_packed_word),
        .i_last_of_run   (o_last_of_run),
        .i_line_end      (o_line_end),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    // Bias towards the rails so black, white and saturated primaries turn up often.
    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: begin
                b = 8'h00;
            end
            1: begin
                b = 8'hff;
            end
            default: begin
                b = 8'($urandom_range(0, 255));
            end
        endcase
        return b;
    endfunction

    // Random pixels grouped into lines of random length; now and then the
    // end-of-line flag is scrambled to break the line structure.
    function automatic t_pair_in random_pair();
        t_pair_in p;
        p.px0.red   = rand_byte();
        p.px0.green = rand_byte();
        p.px0.blue  = rand_byte();
        p.px1.red   = rand_byte();
        p.px1.green = rand_byte();
        p.px1.blue  = rand_byte();
        if (line_left == 0) begin
            line_left = $urandom_range(1, 48);
        end
        line_left--;
        if ($urandom_range(0, 19) == 0) begin
            p.last = 1'($urandom_range(0, 1));
        end else begin
            p.last = (line_left == 0);
        end
        return p;
    endfunction

    // Offer one item and hold it until the block takes it. Bursts of random
    // length are separated by random gaps; long bursts give stretches with
    // no idling on the input side.
    task automatic send_pair(input t_pair_in pair);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 120);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pair_d     <= pair;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_rgb(input logic [7:0] r0, g0, b0, r1, g1, b1, input logic last);
        send_pair({r0, g0, b0, r1, g1, b1, last});
    endtask

    // Drop valid, let every owed word come out, then give the pipeline time
    // to settle before the mode register is touched.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Rails, primaries and secondaries, alternating-bit patterns, and small
    // differences where truncating and flooring division part ways.
    task automatic run_directed();
        send_rgb(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_rgb(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        send_rgb(8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   1'b0);
        send_rgb(8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   1'b0);
        send_rgb(8'd0,   8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 1'b0);
        send_rgb(8'd85,  8'd170, 8'd85,  8'd170, 8'd85,  8'd170, 1'b0);
        send_rgb(8'd0,   8'd17,  8'd0,   8'd7,   8'd0,   8'd7,   1'b0);
        send_rgb(8'd170, 8'd85,  8'd51,  8'd85,  8'd170, 8'd204, 1'b1);
    endtask

    // Receiver: stall in styles of random span, one of them never stalling.
    // Once asked, hold off for a long stretch so the pipeline fills and the
    // block has to stall its input.
    initial begin : receiver
        t_stall_style style;
        int           span;
        i_out_stall <= 1'b0;
        forever begin
            style = t_stall_style'($urandom_range(0, 4));
            span  = $urandom_range(10, 150);
            for (int c = 0; c < span; c++) begin
                if (hold_off_req && !hold_off_done) begin
                    i_out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                    hold_off_done = 1'b1;
                end
                case (style)
                    STALL_NONE: begin
                        i_out_stall <= 1'b0;
                    end
                    STALL_COIN: begin
                        i_out_stall <= 1'($urandom_range(0, 1));
                    end
                    STALL_RARE: begin
                        i_out_stall <= ($urandom_range(0, 7) == 0);
                    end
                    STALL_EVERY_THIRD: begin
                        i_out_stall <= (c % 3 == 2);
                    end
                    default: begin
                        i_out_stall <= (c % 16 >= 10);
                    end
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rgb_pair_to_uyvy_packer_unit regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= MODE_PAIR;
        i_in_valid    <= 1'b0;
        pair_d        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed items, once in each mode
        set_mode(MODE_PAIR);
        run_directed();
        set_mode(MODE_DOUBLED);
        run_directed();

        // random phases, alternating modes; the long hold-off lands in a
        // doubled phase where the output side is the bottleneck
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_mode((ph % 2 == 0) ? MODE_DOUBLED : MODE_PAIR);
            if (ph == 2) begin
                hold_off_req <= 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_pair(random_pair());
            end
        end

        wait_drained();
        if (fail_count == 0 && words_pending == 0) begin
            $display("rgb_pair_to_uyvy_packer_unit regression: pass");
        end else begin
            $display("rgb_pair_to_uyvy_packer_unit regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rgb2uyvy_pkg.sv
rtl/rgb2uyvy_luma.sv
rtl/rgb2uyvy_chroma.sv
rtl/rgb2uyvy_out.sv
rtl/rgb_pair_to_uyvy_packer_unit.sv
sim/uyvy_word_checker.sv
sim/tb_rgb_pair_to_uyvy_packer_unit.sv
